>>> sv/rsslk_pkg.sv
package rsslk_pkg;

  localparam int KNOT_DEPTH = 512;
  localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
  localparam int CNT_W      = KNOT_AW + 1;
  localparam int KNOT_W     = 33;          // {prob, loss}

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 72;

  localparam int SQ_W       = 34;          // squared distance
  localparam int MANT_W     = 31;          // Q1.30 mantissa
  localparam int FRAC_STEPS = 16;
  localparam int DIVD_W     = 35;
  localparam int DIVQ_W     = 17;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int CFG_IDX_W = 3;

  localparam logic [16:0]        ONE_Q16          = 17'd65536;
  localparam logic signed [18:0] LOG_COEF         = 19'sd197283;
  localparam logic signed [16:0] RSS_OFFSET_RESET = 17'sd37773;
  localparam logic [9:0]         KNOT_COUNT_RESET = 10'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RSS_OFFSET = 3'd0,
    REG_HIGH_THR   = 3'd1,
    REG_LOW_THR    = 3'd2,
    REG_KNOT_COUNT = 3'd3
  } reg_idx_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [8:0]         knot_index;
    logic [15:0]        knot_loss;
    logic [16:0]        knot_prob;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } cmd_t;

  typedef struct packed {
    logic signed [16:0] rss_offset;
    logic signed [15:0] high_thr;
    logic signed [15:0] low_thr;
    logic [9:0]         knot_count;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] rss_level;
    logic [16:0]        prob_low;
    logic [16:0]        prob_mid;
    logic [16:0]        prob_high;
  } res_t;

  function automatic logic [16:0] clamp_prob(input logic [16:0] p);
    clamp_prob = (p > ONE_Q16) ? ONE_Q16 : p;
  endfunction

endpackage

>>> sv/rsslk_ram.sv
module rsslk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rsslk_front.sv
module rsslk_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rsslk_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [0:0]                           s_tuser,
  output rsslk_pkg::cmd_t                      q_cmd,
  output logic                                 q_valid,
  input  logic                                 q_pop
);
  import rsslk_pkg::*;

  cmd_t               entries [QDEPTH];
  logic [QAW-1:0]     wr_ptr;
  logic [QAW-1:0]     rd_ptr;
  logic [QAW:0]       count;
  logic               push;
  cmd_t               in_cmd;
  logic signed [15:0] sx, sy, ax, ay;

  // unpack and form the coordinate differences up front
  always_comb begin
    sx = $signed(s_tdata[57:42]);
    sy = $signed(s_tdata[73:58]);
    ax = $signed(s_tdata[89:74]);
    ay = $signed(s_tdata[105:90]);
    in_cmd.func       = func_t'(s_tuser[0]);
    in_cmd.knot_index = s_tdata[8:0];
    in_cmd.knot_loss  = s_tdata[24:9];
    in_cmd.knot_prob  = s_tdata[41:25];
    in_cmd.dx         = {sx[15], sx} - {ax[15], ax};
    in_cmd.dy         = {sy[15], sy} - {ay[15], ay};
  end

  assign s_tready = (count != (QAW+1)'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

>>> sv/rsslk_div.sv
module rsslk_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rsslk_pkg::DIVD_W-1:0]   dividend,
  input  logic [15:0]                    divisor,
  output logic                           done,
  output logic [rsslk_pkg::DIVQ_W-1:0]   quotient
);
  import rsslk_pkg::*;

  logic              busy;
  logic [4:0]        count;
  logic [15:0]       rem;
  logic [15:0]       dsr;
  logic [DIVQ_W-1:0] lowb;
  logic [16:0]       trial;
  logic              qbit;

  // quotient fits in DIVQ_W bits, so the upper part is already below the divisor
  assign trial = {rem, lowb[DIVQ_W-1]};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == 5'(DIVQ_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 16'(dividend >> DIVQ_W);
      lowb     <= dividend[DIVQ_W-1:0];
      dsr      <= divisor;
      count    <= '0;
      quotient <= '0;
    end else if (busy) begin
      rem      <= qbit ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      lowb     <= lowb << 1;
      quotient <= {quotient[DIVQ_W-2:0], qbit};
      count    <= count + 5'd1;
    end
  end

endmodule

>>> sv/rsslk_back.sv
module rsslk_back (
  input  logic            clk,
  input  logic            rst,
  input  rsslk_pkg::cfg_t cfg,
  input  rsslk_pkg::cmd_t q_cmd,
  input  logic            q_valid,
  output logic            q_pop,
  output rsslk_pkg::res_t out_res,
  output logic            out_valid,
  input  logic            out_ready
);
  import rsslk_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_SQ1    = 15'h0002,
    ST_SQ2    = 15'h0004,
    ST_NORM   = 15'h0008,
    ST_SQR    = 15'h0010,
    ST_LMUL   = 15'h0020,
    ST_RSS    = 15'h0040,
    ST_LAST   = 15'h0080,
    ST_LASTW  = 15'h0100,
    ST_SEARCH = 15'h0200,
    ST_IPREP  = 15'h0400,
    ST_IMUL1  = 15'h0800,
    ST_IMUL2  = 15'h1000,
    ST_IDIV   = 15'h2000,
    ST_OUT    = 15'h4000
  } state_t;

  state_t state;

  logic signed [16:0] dx, dy;
  logic [SQ_W-1:0]    acc, norm;
  logic               s_zero;
  logic [5:0]         shift_tot, expo;
  logic [3:0]         step;
  logic [MANT_W-1:0]  mant;
  logic [15:0]        frac;
  logic signed [41:0] prod;
  logic signed [16:0] rss;
  logic signed [17:0] a_h, a_l;
  logic [15:0]        last_loss;
  logic [KNOT_W-1:0]  prev, lo_h, hi_h, lo_l, hi_l;
  logic [KNOT_AW-1:0] rd_idx;
  logic               done_h, done_l;
  logic               sel;
  logic [15:0]        num, den;
  logic [16:0]        plo, phi;
  logic [32:0]        p1;
  logic [16:0]        res_h, res_l;

  // ram
  logic               ram_we;
  logic [KNOT_AW-1:0] ram_waddr, ram_raddr, last_idx;
  logic [KNOT_W-1:0]  ram_wdata, rdata;
  logic [CNT_W-1:0]   n_eff;

  // datapath helpers
  logic [SQ_W-1:0]    sum_sq;
  logic [5:0]         nsh;
  logic               top_zero;
  logic [SQ_W-1:0]    norm_sh;
  logic [5:0]         tot_sh;
  logic [61:0]        msq;
  logic [31:0]        mtop;
  logic signed [22:0] l2;
  logic signed [41:0] rnd;
  logic signed [17:0] loss;
  logic signed [18:0] rss_w;
  logic signed [16:0] rss_sat;
  logic signed [17:0] a_sel;
  logic [KNOT_W-1:0]  lo_sel, hi_sel;
  logic               hit_h, hit_l;
  logic [32:0]        pm;
  logic [DIVD_W-1:0]  numer;
  logic               div_start, div_done;
  logic [DIVQ_W-1:0]  quo;

  // effective knot count, clamped to the table
  always_comb begin
    if (cfg.knot_count < 10'd2) begin
      n_eff = CNT_W'(2);
    end else if (32'(cfg.knot_count) > KNOT_DEPTH) begin
      n_eff = CNT_W'(KNOT_DEPTH);
    end else begin
      n_eff = CNT_W'(cfg.knot_count);
    end
    last_idx = KNOT_AW'(n_eff - CNT_W'(1));
  end

  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign ram_we    = q_pop && (q_cmd.func == FUNC_LOAD) && (32'(q_cmd.knot_index) < KNOT_DEPTH);
  assign ram_waddr = KNOT_AW'(q_cmd.knot_index);
  assign ram_wdata = {q_cmd.knot_prob, q_cmd.knot_loss};

  always_comb begin
    case (state)
      ST_LAST:   ram_raddr = last_idx;
      ST_SEARCH: ram_raddr = rd_idx + 1'b1;
      default:   ram_raddr = '0;
    endcase
  end

  rsslk_ram #(
    .WIDTH(KNOT_W),
    .DEPTH(KNOT_DEPTH)
  ) u_knots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_comb begin
    sum_sq   = acc + SQ_W'(dy * dy);
    nsh      = 6'd32 >> step[2:0];
    top_zero = ((norm >> (6'(SQ_W) - nsh)) == '0);
    norm_sh  = top_zero ? (norm << nsh) : norm;
    tot_sh   = shift_tot + (top_zero ? nsh : 6'd0);
    msq      = 62'(mant) * 62'(mant);
    mtop     = msq[61:30];
    l2       = $signed({1'b0, expo, frac}) - 23'sd1048576;
    rnd      = prod + 42'sd8388608;
    loss     = s_zero ? 18'sd0 : $signed(rnd[41:24]);
    rss_w    = {{2{cfg.rss_offset[16]}}, cfg.rss_offset} - {loss[17], loss};
    if (rss_w > 19'sd65535) begin
      rss_sat = 17'sd65535;
    end else if (rss_w < -19'sd65536) begin
      rss_sat = -17'sd65536;
    end else begin
      rss_sat = rss_w[16:0];
    end
    a_sel  = sel ? a_l : a_h;
    lo_sel = sel ? lo_l : lo_h;
    hi_sel = sel ? hi_l : hi_h;
    hit_h  = (rd_idx != '0) && !done_h &&
             ((rd_idx == last_idx) || ($signed({2'b00, rdata[15:0]}) > a_h));
    hit_l  = (rd_idx != '0) && !done_l &&
             ((rd_idx == last_idx) || ($signed({2'b00, rdata[15:0]}) > a_l));
    pm     = phi * num;
    numer  = DIVD_W'(p1) + DIVD_W'(pm) + DIVD_W'(den >> 1);
  end

  assign div_start = (state == ST_IMUL2);

  rsslk_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(numer),
    .divisor (den),
    .done    (div_done),
    .quotient(quo)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid && q_cmd.func == FUNC_EVAL) begin
            state <= ST_SQ1;
          end
        end
        ST_SQ1:  state <= ST_SQ2;
        ST_SQ2:  state <= ST_NORM;
        ST_NORM: begin
          if (s_zero) begin
            state <= ST_RSS;
          end else if (step == 4'd5) begin
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (step == 4'(FRAC_STEPS - 1)) begin
            state <= ST_LMUL;
          end
        end
        ST_LMUL:  state <= ST_RSS;
        ST_RSS:   state <= ST_LAST;
        ST_LAST:  state <= ST_LASTW;
        ST_LASTW: begin
          if (((a_h <= 0) || (a_h >= $signed({2'b00, rdata[15:0]}))) &&
              ((a_l <= 0) || (a_l >= $signed({2'b00, rdata[15:0]})))) begin
            state <= ST_IPREP;
          end else begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if ((done_h || hit_h) && (done_l || hit_l)) begin
            state <= ST_IPREP;
          end
        end
        ST_IPREP: begin
          if (a_sel <= 0 || a_sel >= $signed({2'b00, last_loss}) ||
              a_sel <= $signed({2'b00, lo_sel[15:0]})) begin
            if (sel) begin
              state <= ST_OUT;
            end
          end else begin
            state <= ST_IMUL1;
          end
        end
        ST_IMUL1: state <= ST_IMUL2;
        ST_IMUL2: state <= ST_IDIV;
        ST_IDIV: begin
          if (div_done) begin
            state <= sel ? ST_OUT : ST_IPREP;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dx <= q_cmd.dx;
        dy <= q_cmd.dy;
      end
      ST_SQ1: acc <= SQ_W'(dx * dx);
      ST_SQ2: begin
        norm      <= sum_sq;
        s_zero    <= (sum_sq == '0);
        shift_tot <= '0;
        step      <= '0;
      end
      ST_NORM: begin
        norm      <= norm_sh;
        shift_tot <= tot_sh;
        step      <= step + 4'd1;
        if (step == 4'd5) begin
          mant <= norm_sh[SQ_W-1 -: MANT_W];
          expo <= 6'(SQ_W - 1) - tot_sh;
          step <= '0;
        end
      end
      // one fraction bit of log2 per squaring
      ST_SQR: begin
        if (mtop[31]) begin
          mant <= mtop[31:1];
          frac <= {frac[14:0], 1'b1};
        end else begin
          mant <= mtop[30:0];
          frac <= {frac[14:0], 1'b0};
        end
        step <= step + 4'd1;
      end
      ST_LMUL: prod <= l2 * LOG_COEF;
      ST_RSS: begin
        rss <= rss_sat;
        a_h <= {rss_sat[16], rss_sat} - {{2{cfg.high_thr[15]}}, cfg.high_thr};
        a_l <= {rss_sat[16], rss_sat} - {{2{cfg.low_thr[15]}}, cfg.low_thr};
      end
      ST_LASTW: begin
        last_loss <= rdata[15:0];
        rd_idx    <= '0;
        done_h    <= (a_h <= 0) || (a_h >= $signed({2'b00, rdata[15:0]}));
        done_l    <= (a_l <= 0) || (a_l >= $signed({2'b00, rdata[15:0]}));
        sel       <= 1'b0;
      end
      ST_SEARCH: begin
        prev   <= rdata;
        rd_idx <= rd_idx + 1'b1;
        if (hit_h) begin
          lo_h   <= prev;
          hi_h   <= rdata;
          done_h <= 1'b1;
        end
        if (hit_l) begin
          lo_l   <= prev;
          hi_l   <= rdata;
          done_l <= 1'b1;
        end
      end
      ST_IPREP: begin
        num <= 16'(a_sel - $signed({2'b00, lo_sel[15:0]}));
        den <= hi_sel[15:0] - lo_sel[15:0];
        plo <= clamp_prob(lo_sel[32:16]);
        phi <= clamp_prob(hi_sel[32:16]);
        if (a_sel <= 0 || a_sel >= $signed({2'b00, last_loss}) ||
            a_sel <= $signed({2'b00, lo_sel[15:0]})) begin
          if (a_sel <= 0) begin
            if (sel) res_l <= '0; else res_h <= '0;
          end else if (a_sel >= $signed({2'b00, last_loss})) begin
            if (sel) res_l <= ONE_Q16; else res_h <= ONE_Q16;
          end else begin
            if (sel) res_l <= clamp_prob(lo_sel[32:16]);
            else res_h <= clamp_prob(lo_sel[32:16]);
          end
          sel <= 1'b1;
        end
      end
      ST_IMUL1: p1 <= plo * (den - num);
      ST_IDIV: begin
        if (div_done) begin
          if (sel) res_l <= quo; else res_h <= quo;
          sel <= 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_res.prob_high <= res_h;
          out_res.prob_low  <= ONE_Q16 - res_l;
          out_res.prob_mid  <= (res_l > res_h) ? (res_l - res_h) : '0;
          out_res.rss_level <= rss;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/rss_level_observation_likelihood.sv
// rss level likelihood: evaluation words (tuser = 1) carry source and agent positions in
// signed q7.8 metres; the block forms the squared distance, its log2 by leading-one
// normalization and sixteen squarings, the free-space loss 20*log10(d) in q8.8 db and the
// saturated rss = rss_offset - loss, then looks up a piecewise-linear cdf in a knot table for
// the high and low thresholds and returns prob_high, prob_mid, prob_low in q1.16 together with
// rss_level. load words (tuser = 0) write one knot {prob, loss} and produce nothing; they are
// kept in order with evaluations, so an evaluation sees every earlier load; knots never loaded
// read as garbage. a load is written as the back end pops it while idle. for an evaluation,
// the table sits in one single-port-read ram and is scanned linearly from the first knot up to
// the knot that brackets the larger argument (up to knot_count), and each of the two
// interpolations runs a bit-serial divider. a two-word queue in front and the result
// register at the output let the input side and the output side stall on their own.
// configuration must be written only while the block is idle; the block does not enforce this.
module rss_level_observation_likelihood (
  input  logic                                 clk,
  input  logic                                 rst,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsslk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [16:0]                          cfg_data,
  // input words
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // knot_index, knot_loss, knot_prob, source_x, source_y, agent_x, agent_y, zero pad
  input  logic [rsslk_pkg::IN_TDATA_W-1:0]     s_tdata,
  // func
  input  logic [0:0]                           s_tuser,
  // result words
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // prob_high, prob_mid, prob_low, rss_level, zero pad
  output logic [rsslk_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import rsslk_pkg::*;

  cfg_t cfg;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;
  res_t res;

  // config registers, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rss_offset <= RSS_OFFSET_RESET;
      cfg.high_thr   <= '0;
      cfg.low_thr    <= '0;
      cfg.knot_count <= KNOT_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_RSS_OFFSET: cfg.rss_offset <= $signed(cfg_data);
        REG_HIGH_THR:   cfg.high_thr   <= $signed(cfg_data[15:0]);
        REG_LOW_THR:    cfg.low_thr    <= $signed(cfg_data[15:0]);
        REG_KNOT_COUNT: cfg.knot_count <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // front end: unpack, take differences, queue
  rsslk_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // back end: knot writes, log, cdf search, interpolation, result register
  rsslk_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_cmd    (q_cmd),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_res  (res),
    .out_valid(m_tvalid),
    .out_ready(m_tready)
  );

  assign m_tdata = {4'b0000, res.rss_level, res.prob_low, res.prob_mid, res.prob_high};

endmodule

>>> sv/rsslk_check.sv
module rsslk_check (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [rsslk_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import rsslk_pkg::*;

  logic [16:0] p_high, p_mid, p_low;
  logic [18:0] p_sum;

  assign p_high = m_tdata[16:0];
  assign p_mid  = m_tdata[33:17];
  assign p_low  = m_tdata[50:34];
  assign p_sum  = 19'(p_high) + 19'(p_mid) + 19'(p_low);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // each probability is within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> p_high <= ONE_Q16 && p_mid <= ONE_Q16 && p_low <= ONE_Q16)
    else $error("probability above one");

  // with a middle band the three levels add to one
  a_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && p_mid != '0 |-> p_sum == 19'(ONE_Q16))
    else $error("level probabilities do not add to one");

endmodule

bind rss_level_observation_likelihood rsslk_check u_check (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
